[hdl/sebt_pkg.sv]
// Shared constants, codes and types for the scanline edge bucket table.
// No dependencies; every other file but sebt_ram imports this package.
package sebt_pkg;

   localparam int SCANLINES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 256;

   localparam int LINE_W   = 10;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // sort key of one edge: start x first, then inverse slope
   typedef struct packed {
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] slope;
   } key_type;

   // stored payload besides the key
   typedef struct packed {
      logic        [LINE_W-1:0] y_max;
      logic signed [VAL_W-1:0]  z;
      logic signed [VAL_W-1:0]  dz;
   } payload_type;

endpackage

[hdl/sebt_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on sebt_pkg.
interface sebt_req_if import sebt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic        [LINE_W-1:0] scanline;
   logic        [LINE_W-1:0] y_max;
   logic signed [VAL_W-1:0]  x_start;
   logic signed [VAL_W-1:0]  inv_slope;
   logic signed [VAL_W-1:0]  z_start;
   logic signed [VAL_W-1:0]  z_step;

   modport source (output valid, cmd, scanline, y_max, x_start, inv_slope, z_start, z_step,
                   input ready);
   modport sink (input valid, cmd, scanline, y_max, x_start, inv_slope, z_start, z_step,
                 output ready);
endinterface

interface sebt_rsp_if import sebt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic        [STATUS_W-1:0] status;
   logic        [LINE_W-1:0]   out_y_max;
   logic signed [VAL_W-1:0]    out_x_start;
   logic signed [VAL_W-1:0]    out_inv_slope;
   logic signed [VAL_W-1:0]    out_z_start;
   logic signed [VAL_W-1:0]    out_z_step;
   logic                      table_empty;

   modport source (output valid, status, out_y_max, out_x_start, out_inv_slope,
                   out_z_start, out_z_step, table_empty, input ready);
   modport sink (input valid, status, out_y_max, out_x_start, out_inv_slope,
                 out_z_start, out_z_step, table_empty, output ready);
endinterface

[hdl/sebt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sebt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/sebt_key_cmp.sv]
// Shared key comparator: a <= b on (x, then slope), signed.
// Depends on sebt_pkg.
module sebt_key_cmp import sebt_pkg::*; (
   input  key_type a,
   input  key_type b,
   output logic    le
);
   // equal x falls through to the slope compare
   assign le = (a.x != b.x) ? (a.x < b.x) : (a.slope <= b.slope);
endmodule

[hdl/scanline_edge_bucket_table.sv]
// Scanline edge bucket table: top level, sequencer and edge store.
// Depends on sebt_pkg, sebt_if, sebt_ram and sebt_key_cmp.
//
// Usage:
//   req_if carries one command per transfer: insert an edge into the bucket of
//   its start scanline, or remove the head edge of a bucket. rsp_if returns
//   exactly one result per command, with a status and the table-empty flag.
//   Buckets are linked lists sorted by (x_start, inv_slope); a new edge goes
//   after entries with an equal key.
// Timing:
//   Cycles from the request transfer to the result: 1 for a rejected command,
//   4 for a remove (2 on an empty bucket), 3 for an insert into an empty
//   bucket, else 3 + w, plus 1 when the edge does not become the head; w counts
//   the entries visited, each one key and link read and one comparator pass.
//   One command is in work at a time; req_if.ready is low while it runs.
// Reset:
//   After reset a clearing pass of max(SCANLINES, MAX_EDGES) cycles empties
//   every bucket and chains the free list; no request is taken meanwhile.
// Stall:
//   The result sits in an output register until taken; the next request is
//   taken in the cycle the result leaves or when the register is empty.
module scanline_edge_bucket_table import sebt_pkg::*; #(
   parameter int SCANLINES = SCANLINES_DEF,
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input logic       clock,
   input logic       reset,
   sebt_req_if.sink   req_if,
   sebt_rsp_if.source rsp_if
);
   localparam int EW    = $clog2(MAX_EDGES + 1);     // pointer incl. end marker
   localparam int AW    = $clog2(MAX_EDGES);
   localparam int HW    = $clog2(SCANLINES);
   localparam int LW    = (HW > LINE_W) ? HW : LINE_W;
   localparam int BW    = $clog2(SCANLINES + 1);
   localparam int CLR_N = (SCANLINES > MAX_EDGES) ? SCANLINES : MAX_EDGES;
   localparam int CW    = $clog2(CLR_N);
   localparam logic [EW-1:0] END_MARK = EW'(MAX_EDGES);
   localparam int KW    = $bits(key_type);
   localparam int PW    = $bits(payload_type);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_INS_HEAD = 4'd2;
   localparam logic [3:0] S_INS_WALK = 4'd3;
   localparam logic [3:0] S_INS_LINK = 4'd4;
   localparam logic [3:0] S_INS_TAIL = 4'd5;
   localparam logic [3:0] S_REM_HEAD = 4'd6;
   localparam logic [3:0] S_REM_RD   = 4'd7;
   localparam logic [3:0] S_REM_FREE = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [HW-1:0] line_ff, line_in;
   key_type       key_new_ff, key_new_in;
   logic [EW-1:0] e_ff, e_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [EW-1:0] free_head_ff, free_head_in;
   logic [BW-1:0] busy_ff, busy_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   key_type             rsp_key_ff, rsp_key_in;
   payload_type         rsp_pay_ff, rsp_pay_in;
   logic                rsp_empty_ff, rsp_empty_in;

   // memory ports
   logic          head_we;
   logic [HW-1:0] head_waddr, head_raddr;
   logic [EW-1:0] head_wdata, head_rdata;
   logic          link_we;
   logic [AW-1:0] link_waddr, link_raddr;
   logic [EW-1:0] link_wdata, link_rdata;
   logic          key_we;
   logic [AW-1:0] key_raddr;
   key_type       key_wdata, key_rdata;
   logic          pay_we;
   logic [AW-1:0] pay_raddr;
   payload_type   pay_wdata, pay_rdata;

   logic          accept, line_ok, key_le, finish;
   logic [STATUS_W-1:0] fin_status;
   logic [LW-1:0] line_ext;
   logic [HW-1:0] line_idx;

   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign line_ext     = LW'(req_if.scanline);
   assign line_idx     = line_ext[HW-1:0];
   assign line_ok      = (32'(req_if.scanline) < SCANLINES);

   sebt_ram #(.WIDTH(EW), .DEPTH(SCANLINES)) u_head (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata));
   sebt_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_link (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(link_raddr), .rdata(link_rdata));
   sebt_ram #(.WIDTH(KW), .DEPTH(MAX_EDGES)) u_key (
      .clock(clock), .we(key_we), .waddr(free_head_ff[AW-1:0]), .wdata(key_wdata),
      .raddr(key_raddr), .rdata(key_rdata));
   sebt_ram #(.WIDTH(PW), .DEPTH(MAX_EDGES)) u_pay (
      .clock(clock), .we(pay_we), .waddr(free_head_ff[AW-1:0]), .wdata(pay_wdata),
      .raddr(pay_raddr), .rdata(pay_rdata));

   // one comparator serves every step of the sorted walk
   sebt_key_cmp u_cmp (.a(key_rdata), .b(key_new_ff), .le(key_le));

   assign key_wdata.x     = req_if.x_start;
   assign key_wdata.slope = req_if.inv_slope;
   assign pay_wdata.y_max = req_if.y_max;
   assign pay_wdata.z     = req_if.z_start;
   assign pay_wdata.dz    = req_if.z_step;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      line_in      = line_ff;
      key_new_in   = key_new_ff;
      e_in         = e_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      free_head_in = free_head_ff;
      busy_in      = busy_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_pay_in   = rsp_pay_ff;

      head_we    = 1'b0;
      head_waddr = line_ff;
      head_wdata = e_ff;
      head_raddr = line_idx;
      link_we    = 1'b0;
      link_waddr = e_ff[AW-1:0];
      link_wdata = cur_ff;
      link_raddr = free_head_ff[AW-1:0];
      key_we     = 1'b0;
      key_raddr  = link_rdata[AW-1:0];
      pay_we     = 1'b0;
      pay_raddr  = head_rdata[AW-1:0];

      finish     = 1'b0;
      fin_status = ST_OK;

      case (state_ff)
         S_CLEAR: begin
            // empty every bucket and chain the free list
            head_we    = (32'(clr_ff) < SCANLINES);
            head_waddr = HW'(clr_ff);
            head_wdata = END_MARK;
            link_we    = (32'(clr_ff) < MAX_EDGES);
            link_waddr = AW'(clr_ff);
            link_wdata = EW'((CW + 1)'(clr_ff) + (CW + 1)'(1));
            clr_in     = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               line_in = line_idx;
               if (req_if.cmd == CMD_INSERT) begin
                  if (!line_ok || free_head_ff == END_MARK) begin
                     finish     = 1'b1;
                     fin_status = ST_FULL;
                  end else begin
                     key_we           = 1'b1;
                     pay_we           = 1'b1;
                     e_in             = free_head_ff;
                     key_new_in.x     = req_if.x_start;
                     key_new_in.slope = req_if.inv_slope;
                     state_in         = S_INS_HEAD;
                  end
               end else begin
                  if (!line_ok) begin
                     finish     = 1'b1;
                     fin_status = ST_EMPTY;
                  end else begin
                     state_in = S_REM_HEAD;
                  end
               end
            end
         end
         S_INS_HEAD: begin
            // pop the free list, start the walk at the bucket head
            free_head_in = link_rdata;
            cur_in       = head_rdata;
            prev_in      = END_MARK;
            link_raddr   = head_rdata[AW-1:0];
            key_raddr    = head_rdata[AW-1:0];
            state_in     = (head_rdata == END_MARK) ? S_INS_LINK : S_INS_WALK;
         end
         S_INS_WALK: begin
            link_raddr = link_rdata[AW-1:0];
            key_raddr  = link_rdata[AW-1:0];
            if (key_le) begin
               prev_in = cur_ff;
               cur_in  = link_rdata;
               if (link_rdata == END_MARK) begin
                  state_in = S_INS_LINK;
               end
            end else begin
               state_in = S_INS_LINK;
            end
         end
         S_INS_LINK: begin
            link_we = 1'b1;
            if (prev_ff == END_MARK) begin
               head_we = 1'b1;
               if (cur_ff == END_MARK) begin
                  busy_in = busy_ff + BW'(1);
               end
               finish = 1'b1;
            end else begin
               state_in = S_INS_TAIL;
            end
         end
         S_INS_TAIL: begin
            link_we    = 1'b1;
            link_waddr = prev_ff[AW-1:0];
            link_wdata = e_ff;
            finish     = 1'b1;
         end
         S_REM_HEAD: begin
            link_raddr = head_rdata[AW-1:0];
            key_raddr  = head_rdata[AW-1:0];
            e_in       = head_rdata;
            if (head_rdata == END_MARK) begin
               finish     = 1'b1;
               fin_status = ST_EMPTY;
            end else begin
               state_in = S_REM_RD;
            end
         end
         S_REM_RD: begin
            // unlink the head, hold its fields for the result
            head_we    = 1'b1;
            head_wdata = link_rdata;
            if (link_rdata == END_MARK) begin
               busy_in = busy_ff - BW'(1);
            end
            rsp_key_in = key_rdata;
            rsp_pay_in = pay_rdata;
            state_in   = S_REM_FREE;
         end
         S_REM_FREE: begin
            link_we      = 1'b1;
            link_wdata   = free_head_ff;
            free_head_in = e_ff;
            finish       = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (finish) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_empty_in  = (busy_in == '0);
         if (state_ff != S_REM_FREE) begin
            rsp_key_in = '0;
            rsp_pay_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      line_ff       <= line_in;
      key_new_ff    <= key_new_in;
      e_ff          <= e_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.out_y_max     = rsp_pay_ff.y_max;
   assign rsp_if.out_x_start   = rsp_key_ff.x;
   assign rsp_if.out_inv_slope = rsp_key_ff.slope;
   assign rsp_if.out_z_start   = rsp_pay_ff.z;
   assign rsp_if.out_z_step    = rsp_pay_ff.dz;
   assign rsp_if.table_empty   = rsp_empty_ff;

`ifndef SYNTH
   a_busy_range: assert property (@(posedge clock) disable iff (reset)
      32'(busy_ff) <= SCANLINES)
      else $error("busy bucket count beyond bucket total");
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      32'(free_head_ff) <= MAX_EDGES)
      else $error("free list head out of range");
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE) || rsp_valid_ff)
      else $error("accepted request neither worked on nor answered");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff && !req_if.ready)
      else $error("traffic during clearing pass");
`endif
endmodule
